@@ src/sbs_pkg.sv @@
package sbs_pkg;

	localparam int TRACK_SLOTS = 8;
	localparam int BIN_COUNT   = 1024;
	localparam int SAMPLE_BITS = 16;

	localparam int REQ_TYPE_W = 3;
	localparam int SLOT_W     = 3;
	localparam int BIN_W      = 10;
	localparam int STATUS_W   = 2;
	localparam int TIMEOUT_W  = 16;
	localparam int AGE_W      = 17;

	localparam int MEM_DEPTH  = TRACK_SLOTS * BIN_COUNT;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int SLOT_IDX_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
	localparam int BIN_IDX_W  = $clog2(BIN_COUNT);

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);
	localparam logic [AGE_W-1:0]     AGE_MAX       = '1;

	localparam logic [REQ_TYPE_W-1:0] REQ_BIN      = REQ_TYPE_W'(0);
	localparam logic [REQ_TYPE_W-1:0] REQ_PRESENCE = REQ_TYPE_W'(1);
	localparam logic [REQ_TYPE_W-1:0] REQ_TICK     = REQ_TYPE_W'(2);
	localparam logic [REQ_TYPE_W-1:0] REQ_STALE    = REQ_TYPE_W'(3);
	localparam logic [REQ_TYPE_W-1:0] REQ_READ     = REQ_TYPE_W'(4);

	localparam logic [STATUS_W-1:0] STATUS_ABSENT  = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] STATUS_ACTIVE  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] STATUS_OFFLINE = STATUS_W'(2);

	typedef struct packed {
		logic [REQ_TYPE_W-1:0]         req_type;
		logic [SLOT_W-1:0]             track_slot;
		logic [BIN_W-1:0]              bin_index;
		logic signed [SAMPLE_BITS-1:0] bin_value;
		logic                          last_bin;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]             out_track;
		logic [BIN_W-1:0]              out_bin;
		logic signed [SAMPLE_BITS-1:0] raw_value;
		logic signed [SAMPLE_BITS-1:0] smoothed_value;
		logic [STATUS_W-1:0]           track_status;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic proc_fire;
		logic clear;
		logic walk;
	} cmd_t;

	typedef struct packed {
		logic in_mem;
		logic in_stale;
		logic out_free;
		logic walk_last;
	} stat_t;

	function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_IDX_W-1:0] s,
			input logic [BIN_IDX_W-1:0] b);
		return ADDR_W'(32'(s) * BIN_COUNT + 32'(b));
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] ema_step(
			input logic signed [SAMPLE_BITS-1:0] x,
			input logic signed [SAMPLE_BITS-1:0] s);
		logic signed [SAMPLE_BITS+2:0] xe;
		logic signed [SAMPLE_BITS+2:0] se;
		logic signed [SAMPLE_BITS+2:0] acc;
		xe  = (SAMPLE_BITS+3)'(x);
		se  = (SAMPLE_BITS+3)'(s);
		acc = xe + (se <<< 1) + se + (SAMPLE_BITS+3)'(2);
		acc = acc >>> 2;
		return SAMPLE_BITS'(acc);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] decay_step(
			input logic signed [SAMPLE_BITS-1:0] s);
		logic signed [SAMPLE_BITS+2:0] se;
		logic signed [SAMPLE_BITS+2:0] acc;
		se  = (SAMPLE_BITS+3)'(s);
		acc = se + (se <<< 1);
		if (acc[SAMPLE_BITS+2]) begin
			acc = acc + (SAMPLE_BITS+3)'(3);
		end
		acc = acc >>> 2;
		return SAMPLE_BITS'(acc);
	endfunction

endpackage

@@ src/sbs_ram.sv @@
module sbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/sbs_ctrl.sv @@
module sbs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  sbs_pkg::stat_t st,
	output logic          req_ready,
	output sbs_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROC,
		ST_WALK,
		ST_WALK_END
	} state_t;

	state_t state_q;

	always_comb begin
		req_ready     = (state_q == ST_IDLE);
		cmd.accept    = (state_q == ST_IDLE) && req_valid;
		cmd.proc_fire = (state_q == ST_PROC) && st.out_free;
		cmd.clear     = (state_q == ST_CLEAR);
		cmd.walk      = (state_q == ST_WALK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (st.walk_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						if (st.in_mem) begin
							state_q <= ST_PROC;
						end else if (st.in_stale) begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_PROC: begin
					if (st.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (st.walk_last) begin
						state_q <= ST_WALK_END;
					end
				end
				ST_WALK_END: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/sbs_dp.sv @@
module sbs_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sbs_pkg::cmd_t                    cmd,
	input  sbs_pkg::req_t                    req_data,
	input  logic                             cfg_valid,
	input  logic [sbs_pkg::TIMEOUT_W-1:0]    cfg_data,
	input  logic                             rsp_ready,
	output sbs_pkg::stat_t                   st,
	output logic                             rsp_valid,
	output sbs_pkg::rsp_t                    rsp_data
);

	localparam int NS = sbs_pkg::TRACK_SLOTS;
	localparam int SW = sbs_pkg::SAMPLE_BITS;

	logic [sbs_pkg::TIMEOUT_W-1:0] timeout_q;
	logic [NS-1:0] present_q;
	logic [NS-1:0] offline_q;
	logic [NS-1:0] has_spec_q;
	logic [NS-1:0] reseed_q;
	logic [NS-1:0] offl_mask_q;
	logic [NS-1:0] decay_mask_q;
	logic [NS-1:0] go_off;
	logic [sbs_pkg::AGE_W-1:0] age_q [NS];

	sbs_pkg::req_t item_q;
	sbs_pkg::rsp_t out_q;
	sbs_pkg::rsp_t out_d;
	logic          out_valid_q;

	logic [sbs_pkg::SLOT_IDX_W-1:0] walk_slot_q;
	logic [sbs_pkg::BIN_IDX_W-1:0]  walk_bin_q;
	logic [sbs_pkg::ADDR_W-1:0]     walk_addr;
	logic                           wv_s1;
	logic [sbs_pkg::ADDR_W-1:0]     waddr_s1;
	logic [sbs_pkg::SLOT_IDX_W-1:0] wslot_s1;

	logic                           in_slot_ok;
	logic [sbs_pkg::SLOT_IDX_W-1:0] in_slot;
	logic [sbs_pkg::ADDR_W-1:0]     in_addr;
	logic                           it_slot_ok;
	logic                           it_bin_ok;
	logic [sbs_pkg::SLOT_IDX_W-1:0] it_slot;
	logic [sbs_pkg::ADDR_W-1:0]     it_addr;
	logic                           it_is_bin;
	logic                           it_reseed;
	logic signed [SW-1:0]           new_sm;

	logic                       mem_re;
	logic [sbs_pkg::ADDR_W-1:0] mem_raddr;
	logic                       raw_we;
	logic [sbs_pkg::ADDR_W-1:0] raw_waddr;
	logic [SW-1:0]              raw_wdata;
	logic [SW-1:0]              raw_rdata;
	logic                       sm_we;
	logic [sbs_pkg::ADDR_W-1:0] sm_waddr;
	logic [SW-1:0]              sm_wdata;
	logic [SW-1:0]              sm_rdata;

	assign in_slot_ok = 32'(req_data.track_slot) < 32'(NS);
	assign in_slot    = sbs_pkg::SLOT_IDX_W'(req_data.track_slot);
	assign in_addr    = sbs_pkg::mem_addr(in_slot,
		sbs_pkg::BIN_IDX_W'(req_data.bin_index));

	assign it_slot_ok = 32'(item_q.track_slot) < 32'(NS);
	assign it_bin_ok  = 32'(item_q.bin_index) < 32'(sbs_pkg::BIN_COUNT);
	assign it_slot    = sbs_pkg::SLOT_IDX_W'(item_q.track_slot);
	assign it_addr    = sbs_pkg::mem_addr(it_slot,
		sbs_pkg::BIN_IDX_W'(item_q.bin_index));
	assign it_is_bin  = (item_q.req_type == sbs_pkg::REQ_BIN);
	assign it_reseed  = !present_q[it_slot] || offline_q[it_slot] || reseed_q[it_slot];
	assign new_sm     = it_reseed ? item_q.bin_value
		: sbs_pkg::ema_step(item_q.bin_value, $signed(sm_rdata));

	assign walk_addr = sbs_pkg::mem_addr(walk_slot_q, walk_bin_q);

	assign st.in_mem    = (req_data.req_type == sbs_pkg::REQ_BIN)
		|| (req_data.req_type == sbs_pkg::REQ_READ);
	assign st.in_stale  = (req_data.req_type == sbs_pkg::REQ_STALE);
	assign st.out_free  = !out_valid_q || rsp_ready;
	assign st.walk_last = (walk_slot_q == sbs_pkg::SLOT_IDX_W'(NS - 1))
		&& (walk_bin_q == sbs_pkg::BIN_IDX_W'(sbs_pkg::BIN_COUNT - 1));

	always_comb begin
		for (int i = 0; i < NS; i++) begin
			go_off[i] = present_q[i] && !offline_q[i] && has_spec_q[i]
				&& (age_q[i] > sbs_pkg::AGE_W'(timeout_q));
		end
	end

	// memory port steering
	always_comb begin
		mem_re    = cmd.walk || (cmd.accept && st.in_mem);
		mem_raddr = cmd.walk ? walk_addr : in_addr;

		raw_we    = 1'b0;
		raw_waddr = it_addr;
		raw_wdata = item_q.bin_value;
		sm_we     = 1'b0;
		sm_waddr  = it_addr;
		sm_wdata  = new_sm;
		if (cmd.clear) begin
			raw_we    = 1'b1;
			raw_waddr = walk_addr;
			raw_wdata = '0;
			sm_we     = 1'b1;
			sm_waddr  = walk_addr;
			sm_wdata  = '0;
		end else if (wv_s1) begin
			raw_we    = offl_mask_q[wslot_s1];
			raw_waddr = waddr_s1;
			raw_wdata = '0;
			sm_we     = decay_mask_q[wslot_s1];
			sm_waddr  = waddr_s1;
			sm_wdata  = sbs_pkg::decay_step($signed(sm_rdata));
		end else if (cmd.proc_fire && it_is_bin && it_slot_ok && it_bin_ok) begin
			raw_we = 1'b1;
			sm_we  = 1'b1;
		end
	end

	sbs_ram #(
		.WIDTH(SW),
		.DEPTH(sbs_pkg::MEM_DEPTH)
	) u_raw_ram (
		.clk  (clk),
		.we   (raw_we),
		.waddr(raw_waddr),
		.wdata(raw_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(raw_rdata)
	);

	sbs_ram #(
		.WIDTH(SW),
		.DEPTH(sbs_pkg::MEM_DEPTH)
	) u_sm_ram (
		.clk  (clk),
		.we   (sm_we),
		.waddr(sm_waddr),
		.wdata(sm_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(sm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= sbs_pkg::TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= req_data;
		end
		waddr_s1 <= walk_addr;
		wslot_s1 <= walk_slot_q;
	end

	// sweep counters, shared by the reset clear and the stale walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_slot_q <= '0;
			walk_bin_q  <= '0;
			wv_s1       <= 1'b0;
		end else begin
			wv_s1 <= cmd.walk;
			if (cmd.accept && st.in_stale) begin
				walk_slot_q <= '0;
				walk_bin_q  <= '0;
			end else if (cmd.clear || cmd.walk) begin
				if (walk_bin_q == sbs_pkg::BIN_IDX_W'(sbs_pkg::BIN_COUNT - 1)) begin
					walk_bin_q <= '0;
					if (walk_slot_q == sbs_pkg::SLOT_IDX_W'(NS - 1)) begin
						walk_slot_q <= '0;
					end else begin
						walk_slot_q <= walk_slot_q + sbs_pkg::SLOT_IDX_W'(1);
					end
				end else begin
					walk_bin_q <= walk_bin_q + sbs_pkg::BIN_IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q    <= '0;
			offline_q    <= '0;
			has_spec_q   <= '0;
			reseed_q     <= '0;
			offl_mask_q  <= '0;
			decay_mask_q <= '0;
			for (int i = 0; i < NS; i++) begin
				age_q[i] <= '0;
			end
		end else if (cmd.accept) begin
			case (req_data.req_type)
				sbs_pkg::REQ_PRESENCE: begin
					if (in_slot_ok && !present_q[in_slot]) begin
						present_q[in_slot]  <= 1'b1;
						offline_q[in_slot]  <= 1'b0;
						has_spec_q[in_slot] <= 1'b0;
						reseed_q[in_slot]   <= 1'b0;
						age_q[in_slot]      <= '0;
					end
				end
				sbs_pkg::REQ_TICK: begin
					for (int i = 0; i < NS; i++) begin
						if (present_q[i] && age_q[i] != sbs_pkg::AGE_MAX) begin
							age_q[i] <= age_q[i] + sbs_pkg::AGE_W'(1);
						end
					end
				end
				sbs_pkg::REQ_STALE: begin
					offline_q    <= offline_q | go_off;
					offl_mask_q  <= go_off;
					decay_mask_q <= present_q & offline_q;
				end
				default: begin
				end
			endcase
		end else if (cmd.proc_fire && it_is_bin && it_slot_ok) begin
			present_q[it_slot]  <= 1'b1;
			offline_q[it_slot]  <= 1'b0;
			has_spec_q[it_slot] <= 1'b1;
			age_q[it_slot]      <= '0;
			reseed_q[it_slot]   <= item_q.last_bin ? 1'b0 : it_reseed;
		end
	end

	always_comb begin
		out_d.out_track      = item_q.track_slot;
		out_d.out_bin        = item_q.bin_index;
		out_d.raw_value      = '0;
		out_d.smoothed_value = '0;
		out_d.track_status   = sbs_pkg::STATUS_ABSENT;
		if (it_slot_ok) begin
			if (it_is_bin || offline_q[it_slot] == 1'b0) begin
				out_d.track_status = (it_is_bin || present_q[it_slot])
					? sbs_pkg::STATUS_ACTIVE : sbs_pkg::STATUS_ABSENT;
			end else begin
				out_d.track_status = sbs_pkg::STATUS_OFFLINE;
			end
			if (it_bin_ok) begin
				out_d.raw_value      = it_is_bin ? item_q.bin_value : $signed(raw_rdata);
				out_d.smoothed_value = it_is_bin ? new_sm : $signed(sm_rdata);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.proc_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.proc_fire) begin
			out_q <= out_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

@@ src/spectrum_bin_smoother_with_timeout_core.sv @@
// Spectrum bin smoother: raw and smoothed spectra for a set of track slots.
// Request channel (req_valid/req_ready/req_data) takes bin samples, presence
// heartbeats, ticks, stale checks and bin reads. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns one response per bin or read request.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes timeout_ticks; it is
// always ready and is to be written only while the block is idle.
// A bin or read request is accepted and its memory words are read at that
// edge; in the PROC state the response is formed from those words (a bin
// request also writes back both bin memories) and registered once the output
// register is free, and only then is the next request taken. So no new bin
// or read request is taken before the last one is through. Heartbeats and
// ticks leave req_ready high. A stale check sweeps every bin of every slot,
// one per cycle.
// After reset a clearing pass zeroes both bin memories, one entry per cycle,
// and req_ready stays low meanwhile.
// If the receiver stalls, the response is held in the output register and
// the block still accepts the next request; that request waits for the
// output register to free up before it completes.
module spectrum_bin_smoother_with_timeout_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  sbs_pkg::req_t                 req_data,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output sbs_pkg::rsp_t                 rsp_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sbs_pkg::TIMEOUT_W-1:0] cfg_data
);

	sbs_pkg::cmd_t  cmd;
	sbs_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	sbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.st       (st),
		.req_ready(req_ready),
		.cmd      (cmd)
	);

	sbs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req_data),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.rsp_ready(rsp_ready),
		.st       (st),
		.rsp_valid(rsp_valid),
		.rsp_data (rsp_data)
	);

endmodule

@@ src/sbs_chk.sv @@
module sbs_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input sbs_pkg::req_t req_data,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input sbs_pkg::rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	a_busy_after_long: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_data.req_type == sbs_pkg::REQ_BIN
			|| req_data.req_type == sbs_pkg::REQ_READ
			|| req_data.req_type == sbs_pkg::REQ_STALE)
		|=> !req_ready)
		else $error("request taken while previous one still in progress");

	a_ready_after_short: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_data.req_type == sbs_pkg::REQ_TICK
			|| req_data.req_type == sbs_pkg::REQ_PRESENCE)
		|=> req_ready)
		else $error("tick or heartbeat stalled the request channel");

	a_bin_echo: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.req_type == sbs_pkg::REQ_BIN && !rsp_valid
		|-> ##2 rsp_valid && rsp_data.raw_value == $past(req_data.bin_value, 2)
			&& rsp_data.track_status == sbs_pkg::STATUS_ACTIVE)
		else $error("bin response missing or wrong");

endmodule

bind spectrum_bin_smoother_with_timeout_core sbs_chk u_sbs_chk (.*);
